### hdl/arlp_pkg.sv
// Shared constants, codes and types of the address registry.
package arlp_pkg;

  // Table geometry; the depth is a power of two
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned HASH_SHIFT  = 16;

  // Field widths
  localparam int unsigned KEY_W    = 47;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned STATUS_W = 3;

  // Command codes
  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_RELEASE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_ZEROKEY  = 3'd4;

  // Access request to the slot tables
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_key_en;
    logic              wr_size_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [KEY_W-1:0]  wr_key;
    logic [DATA_W-1:0] wr_size;
  } tbl_req_t;

endpackage

### hdl/address_registry_linear_probe.sv
// Region registry: open-addressing table with linear probing over slot memories.
//
// Input channel (in_valid_i/in_ready_o) takes one item: cmd_i, key_i, count_i,
// elem_size_i. Output channel (out_valid_o/out_ready_i) returns one item per
// input: status_o, slot_o, freed_size_o.
// Register stores key and count*elem_size in the first empty slot found from
// the home slot (key bits from 16 up); release clears the first slot holding
// the key and returns its size.
// From acceptance, a zero key or an overflow goes straight to the response; a
// release probes 1 to 4096 slots from the home slot, and a register first forms
// count*elem_size from 32x32 partial products in the multiplier, then probes.
// A miss or a full table probes all 4096 slots. The probe loop issues one key
// memory read per cycle and compares it in the cycle after; the block handles one
// item at a time and takes the next one in the cycle after it loads the result
// into the output register, and a write lands before the next read.
// After reset the block sweeps all 4096 slots of the key memory to zero, one slot
// per cycle, with in_ready_o low. The result sits in an output register:
// the next item is accepted while it waits, and a stalled receiver holds the
// following result in the final state until the register frees.
module address_registry_linear_probe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [arlp_pkg::KEY_W-1:0]    key_i,
  input  logic [arlp_pkg::DATA_W-1:0]   count_i,
  input  logic [arlp_pkg::DATA_W-1:0]   elem_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [arlp_pkg::STATUS_W-1:0] status_o,
  output logic [arlp_pkg::IDX_W-1:0]    slot_o,
  output logic [arlp_pkg::DATA_W-1:0]   freed_size_o
);
  import arlp_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // Control state
  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             out_valid_q, out_valid_d;

  // Item and result payload
  logic                cmd_q, cmd_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [DATA_W-1:0]   count_q, count_d;
  logic [DATA_W-1:0]   esize_q, esize_d;
  logic [IDX_W-1:0]    cmp_addr_q, cmp_addr_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [IDX_W-1:0]    res_slot_q, res_slot_d;
  logic [DATA_W-1:0]   res_freed_q, res_freed_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [IDX_W-1:0]    out_slot_q;
  logic [DATA_W-1:0]   out_freed_q;
  logic                out_load;

  tbl_req_t          tbl_req;
  logic [KEY_W-1:0]  rd_key;
  logic [DATA_W-1:0] rd_size;
  logic              mul_start;
  logic              mul_done;
  logic [DATA_W-1:0] mul_product;

  logic [DATA_W-1:0] half_sum;
  logic              ovf;
  logic [KEY_W-1:0]  key_shifted;
  logic [IDX_W-1:0]  home;
  logic [IDX_W-1:0]  ptr_next;
  logic              hit;
  logic              last;

  arlp_table u_table (
    .clk_i     (clk_i),
    .req_i     (tbl_req),
    .rd_key_o  (rd_key),
    .rd_size_o (rd_size)
  );

  arlp_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (count_q),
    .b_i       (esize_q),
    .done_o    (mul_done),
    .product_o (mul_product)
  );

  // Overflow test on the halved operands, home slot and probe helpers
  assign half_sum    = {1'b0, count_i[DATA_W-1:1]} + {1'b0, elem_size_i[DATA_W-1:1]};
  assign ovf         = half_sum[DATA_W-1];
  assign key_shifted = key_i >> HASH_SHIFT;
  assign home        = key_shifted[IDX_W-1:0];
  assign ptr_next    = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
  assign last        = (cnt_q == LAST_IDX);
  assign hit         = cmp_vld_q &&
                       ((cmd_q == CMD_REGISTER) ? (rd_key == '0) : (rd_key == key_q));
  assign out_load    = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  // Sequence the clearing sweep, item acceptance, multiply wait, probe loop and response
  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    cmp_vld_d    = 1'b0;
    cmp_addr_d   = cmp_addr_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    count_d      = count_q;
    esize_d      = esize_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_freed_d  = res_freed_q;
    mul_start    = 1'b0;
    tbl_req      = '0;

    unique case (state_q)
      S_CLEAR: begin
        tbl_req.wr_key_en = 1'b1;
        tbl_req.wr_addr   = ptr_q;
        ptr_d             = ptr_next;
        if (ptr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = cmd_i;
          key_d       = key_i;
          count_d     = count_i;
          esize_d     = elem_size_i;
          ptr_d       = home;
          cnt_d       = '0;
          res_slot_d  = '0;
          res_freed_d = '0;
          if (key_i == '0) begin
            res_status_d = STATUS_ZEROKEY;
            state_d      = S_RESP;
          end else if (cmd_i == CMD_REGISTER) begin
            if (ovf) begin
              res_status_d = STATUS_OVERFLOW;
              state_d      = S_RESP;
            end else begin
              mul_start = 1'b1;
              state_d   = S_MUL;
            end
          end else begin
            state_d = S_PROBE;
          end
        end
      end

      S_MUL: begin
        if (mul_done) begin
          state_d = S_PROBE;
        end
      end

      S_PROBE: begin
        if (hit) begin
          // Claim or clear the matching slot and finish
          tbl_req.wr_key_en  = 1'b1;
          tbl_req.wr_size_en = (cmd_q == CMD_REGISTER);
          tbl_req.wr_addr    = cmp_addr_q;
          tbl_req.wr_key     = (cmd_q == CMD_REGISTER) ? key_q : '0;
          tbl_req.wr_size    = mul_product;
          res_status_d       = STATUS_OK;
          res_slot_d         = cmp_addr_q;
          res_freed_d        = (cmd_q == CMD_REGISTER) ? '0 : rd_size;
          state_d            = S_RESP;
        end else if (cmp_vld_q && last) begin
          res_status_d = (cmd_q == CMD_REGISTER) ? STATUS_FULL : STATUS_NOTFOUND;
          state_d      = S_RESP;
        end else begin
          if (cmp_vld_q) begin
            cnt_d = cnt_q + 1'b1;
          end
          // Issue the next slot read
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = ptr_q;
          ptr_d           = ptr_next;
          cmp_vld_d       = 1'b1;
          cmp_addr_d      = ptr_q;
        end
      end

      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the output item until taken
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ptr_q       <= '0;
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    count_q      <= count_d;
    esize_q      <= esize_d;
    cmp_addr_q   <= cmp_addr_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_freed_q  <= res_freed_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_freed_q  <= res_freed_q;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign slot_o       = out_slot_q;
  assign freed_size_o = out_freed_q;

  // No item is taken during the clearing sweep
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("input accepted during clearing sweep");

  // Key memory is written only by the sweep or a probe hit
  a_key_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_req.wr_key_en |-> (state_q == S_CLEAR || hit))
    else $error("unexpected key memory write");

  // A pending compare belongs to the probe loop
  a_cmp_in_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == S_PROBE))
    else $error("compare stage valid outside probe");

  // A failed item reports no slot and no size
  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_OK) |-> (slot_o == '0 && freed_size_o == '0))
    else $error("failed item carries slot or size");

  // A register item never returns a size
  a_register_no_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE && hit && cmd_q == CMD_REGISTER) |=> (res_freed_q == '0))
    else $error("register item returned a size");

endmodule

### hdl/arlp_mul.sv
// Multi-cycle 64x64 multiplier keeping the low 64 bits, one 32x32 product per cycle.
module arlp_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [arlp_pkg::DATA_W-1:0] a_i,
  input  logic [arlp_pkg::DATA_W-1:0] b_i,
  output logic                      done_o,
  output logic [arlp_pkg::DATA_W-1:0] product_o
);
  import arlp_pkg::*;

  localparam int unsigned HALF_W = DATA_W / 2;

  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;
  localparam logic [1:0] STEP_END = 2'd3;

  logic              busy_q, busy_d;
  logic [1:0]        step_q, step_d;
  logic              done_q, done_d;
  logic [DATA_W-1:0] prod_q, acc_q;
  logic [HALF_W-1:0] op_a, op_b;
  logic [DATA_W-1:0] mul_res;

  // Select the partial product for this step
  always_comb begin
    case (step_q)
      STEP_LL: begin
        op_a = a_i[HALF_W-1:0];
        op_b = b_i[HALF_W-1:0];
      end
      STEP_LH: begin
        op_a = a_i[HALF_W-1:0];
        op_b = b_i[DATA_W-1:HALF_W];
      end
      STEP_HL: begin
        op_a = a_i[DATA_W-1:HALF_W];
        op_b = b_i[HALF_W-1:0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_res = DATA_W'(op_a) * DATA_W'(op_b);

  // Advance the step sequence
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_LL;
    end else if (busy_q) begin
      step_d = step_q + 2'd1;
      if (step_q == STEP_END) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_LL;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  // Register each partial product, then fold it into the sum
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      prod_q <= mul_res;
      case (step_q) inside
        STEP_LH: acc_q <= prod_q;
        STEP_HL, STEP_END: acc_q <= acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

### hdl/arlp_table.sv
// Slot key and slot size memories with one write and one registered read port.
module arlp_table (
  input  logic                        clk_i,
  input  arlp_pkg::tbl_req_t          req_i,
  output logic [arlp_pkg::KEY_W-1:0]  rd_key_o,
  output logic [arlp_pkg::DATA_W-1:0] rd_size_o
);
  import arlp_pkg::*;

  logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
  logic [DATA_W-1:0] size_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  rd_key_q;
  logic [DATA_W-1:0] rd_size_q;

  // Write the addressed entries
  always_ff @(posedge clk_i) begin
    if (req_i.wr_key_en) begin
      key_mem[req_i.wr_addr] <= req_i.wr_key;
    end
    if (req_i.wr_size_en) begin
      size_mem[req_i.wr_addr] <= req_i.wr_size;
    end
  end

  // Read both memories at the same slot into registered outputs
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_key_q  <= key_mem[req_i.rd_addr];
      rd_size_q <= size_mem[req_i.rd_addr];
    end
  end

  assign rd_key_o  = rd_key_q;
  assign rd_size_o = rd_size_q;

endmodule
